/* rtl/assert_macros.svh */
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rtp_pkg.sv */
// Types, codes and constants of the retransmit timer pool.
package rtp_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int CLOCK_W       = 40;
  localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  RETRY_RESET   = 8'd5;

  // command codes
  localparam logic [3:0] CMD_TICK    = 4'd0;
  localparam logic [3:0] CMD_ACQUIRE = 4'd1;
  localparam logic [3:0] CMD_INIT    = 4'd2;
  localparam logic [3:0] CMD_START   = 4'd3;
  localparam logic [3:0] CMD_STOP    = 4'd4;
  localparam logic [3:0] CMD_CHECK   = 4'd5;
  localparam logic [3:0] CMD_RETRY   = 4'd6;
  localparam logic [3:0] CMD_DEINIT  = 4'd7;
  localparam logic [3:0] CMD_RELEASE = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NO_SLOT   = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  typedef struct packed {
    logic [3:0] cmd;
    logic [2:0] slot;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] granted_slot;
    logic       is_running;
    logic       is_expired;
    logic       retry_left;
    logic [7:0] retries_done;
  } out_t;

  // per-slot record held in the slot memory
  typedef struct packed {
    logic               running;
    logic               expired;
    logic [7:0]         retries;
    logic [CLOCK_W-1:0] deadline;
  } entry_t;

  // side effects of one command outside the slot record
  typedef struct packed {
    logic wr_entry;
    logic set_taken;
    logic clr_taken;
    logic tick;
  } ctl_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

/* rtl/retransmit_timer_pool.sv */
// Retransmit timer pool: top level with command sequencer and slot memory.
// Flow: accepting a command beat starts the registered slot memory read and
//   moves to execute, where the read-modify-write waits for a free result register;
//   a new command is accepted only in idle, so output stalls hold the next one.
// Reset: clock, taken flags and entry valid bits clear at once; timeout 1000,
//   retry limit 5. No clearing pass: entries not yet written read as zero.
module retransmit_timer_pool #(
  parameter int SLOTS = rtp_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rtp_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data
);
  import rtp_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = $bits(entry_t);

  state_t state, state_next;

  // configuration registers
  logic [15:0] timeout_len;
  logic [7:0]  retry_limit;

  // shared clock and per-slot flags kept in flops
  logic [CLOCK_W-1:0] now_ms;
  logic [SLOTS-1:0]   taken;
  logic [SLOTS-1:0]   ent_valid;   // entry written since reset

  // command held while it executes
  logic [3:0]    item_cmd;
  logic [AW-1:0] item_addr;
  logic          item_in_range;
  logic          item_found;

  // accept-side decode
  logic          accept;
  logic          finish;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          slot_in_range;
  logic [AW-1:0] acc_addr;

  // slot memory
  logic          ram_we;
  logic [EW-1:0] ram_q;
  entry_t        entry_q;
  entry_t        entry_d;
  ctl_t          ctl;
  out_t          result;

  assign accept = in_valid && in_ready;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!taken[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  // slot field is 3 bits; a small pool can be addressed past its end
  assign slot_in_range = 7'(in_data.slot) < 7'(SLOTS);
  assign acc_addr      = (in_data.cmd == CMD_ACQUIRE) ? free_idx : AW'(in_data.slot);

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd      <= in_data.cmd;
      item_addr     <= acc_addr;
      item_in_range <= slot_in_range;
      item_found    <= free_found;
    end
  end

  rtp_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_addr),
    .wdata (entry_d),
    .re    (accept),
    .raddr (acc_addr),
    .rdata (ram_q)
  );

  // an entry never written reads as its reset value (all zero)
  assign entry_q = ent_valid[item_addr] ? entry_t'(ram_q) : '0;

  rtp_exec #(
    .AW (AW)
  ) u_exec (
    .cmd         (item_cmd),
    .in_range    (item_in_range),
    .acq_found   (item_found),
    .addr        (item_addr),
    .entry_q     (entry_q),
    .now_ms      (now_ms),
    .timeout_len (timeout_len),
    .retry_limit (retry_limit),
    .entry_d     (entry_d),
    .ctl         (ctl),
    .result      (result)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: execution completes once the output register is free
  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    ram_we   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EXEC: begin
        finish = !out_valid || out_ready;
        ram_we = finish && ctl.wr_entry;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      timeout_len <= TIMEOUT_RESET;
      retry_limit <= RETRY_RESET;
      now_ms      <= '0;
      taken       <= '0;
      ent_valid   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout_len <= cfg_data;
          CFG_RETRY:   retry_limit <= cfg_data[7:0];
          default:     timeout_len <= timeout_len;
        endcase
      end
      if (finish) begin
        if (ctl.tick && (now_ms != CLOCK_MAX)) begin
          now_ms <= now_ms + CLOCK_W'(1);
        end
        if (ctl.set_taken) begin
          taken[item_addr] <= 1'b1;
        end
        if (ctl.clr_taken) begin
          taken[item_addr] <= 1'b0;
        end
        if (ctl.wr_entry) begin
          ent_valid[item_addr] <= 1'b1;
        end
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded only when it is free or being drained
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= result;
    end
  end

  `ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC, "accepted beat not executing")
  `ASSERT_IMPLIES(a_we_exec, clk, rst, ram_we, state == S_EXEC && finish, "stray slot write")
  `ASSERT_NEXT(a_clock_mono, clk, rst, 1'b1, now_ms >= $past(now_ms), "clock went backward")
  `ASSERT_NEXT(a_finish_out, clk, rst, finish, out_valid && state == S_IDLE, "result beat lost")

endmodule

/* rtl/rtp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rtp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rtp_exec.sv */
// Command execution: new slot record, side effects and result beat.
module rtp_exec #(
  parameter int AW = 3
) (
  input  logic [3:0]                  cmd,
  input  logic                        in_range,
  input  logic                        acq_found,
  input  logic [AW-1:0]               addr,
  input  rtp_pkg::entry_t             entry_q,
  input  logic [rtp_pkg::CLOCK_W-1:0] now_ms,
  input  logic [15:0]                 timeout_len,
  input  logic [7:0]                  retry_limit,
  output rtp_pkg::entry_t             entry_d,
  output rtp_pkg::ctl_t               ctl,
  output rtp_pkg::out_t               result
);
  import rtp_pkg::*;

  logic [CLOCK_W:0]   dl_sum;
  logic [CLOCK_W-1:0] dl_armed;
  logic [1:0]         status;
  logic               report;

  assign dl_sum   = {1'b0, now_ms} + (CLOCK_W + 1)'(timeout_len);
  assign dl_armed = dl_sum[CLOCK_W] ? CLOCK_MAX : dl_sum[CLOCK_W-1:0];

  always_comb begin
    entry_d = entry_q;
    ctl     = '0;
    status  = ST_OK;
    report  = 1'b1;
    if (cmd == CMD_TICK) begin
      ctl.tick = 1'b1;
      report   = 1'b0;
    end else if (cmd == CMD_ACQUIRE) begin
      if (acq_found) begin
        ctl.set_taken   = 1'b1;
        ctl.wr_entry    = 1'b1;
        entry_d.running = 1'b0;
        entry_d.expired = 1'b0;
        entry_d.retries = '0;
      end else begin
        status = ST_NO_SLOT;
        report = 1'b0;
      end
    end else if (!in_range) begin
      status = ST_INVALID;
      report = 1'b0;
    end else begin
      unique case (cmd)
        CMD_INIT: begin
          ctl.wr_entry = 1'b1;
          entry_d      = '0;
        end
        CMD_START: begin
          ctl.wr_entry     = 1'b1;
          entry_d.running  = 1'b1;
          entry_d.expired  = 1'b0;
          entry_d.deadline = dl_armed;
        end
        CMD_STOP: begin
          ctl.wr_entry    = 1'b1;
          entry_d.running = 1'b0;
          entry_d.expired = 1'b0;
        end
        CMD_CHECK: begin
          if (!entry_q.running || (now_ms < entry_q.deadline)) begin
            status = ST_INVALID;
          end else begin
            ctl.wr_entry    = 1'b1;
            entry_d.running = 1'b0;
            entry_d.expired = 1'b1;
          end
        end
        CMD_RETRY: begin
          if (entry_q.retries >= retry_limit) begin
            status = ST_EXHAUSTED;
          end else begin
            ctl.wr_entry     = 1'b1;
            entry_d.retries  = entry_q.retries + 8'd1;
            entry_d.running  = 1'b1;
            entry_d.expired  = 1'b0;
            entry_d.deadline = dl_armed;
          end
        end
        CMD_DEINIT: begin
          ctl.wr_entry    = 1'b1;
          entry_d.running = 1'b0;
          entry_d.expired = 1'b0;
          entry_d.retries = '0;
        end
        CMD_RELEASE: begin
          ctl.clr_taken = 1'b1;
        end
        default: begin
          status = ST_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    result        = '0;
    result.status = status;
    if (report) begin
      result.is_running   = entry_d.running;
      result.is_expired   = entry_d.expired;
      result.retry_left   = entry_d.retries < retry_limit;
      result.retries_done = entry_d.retries;
    end
    if (cmd == CMD_ACQUIRE && acq_found) begin
      result.granted_slot = 3'(addr);
    end
  end

endmodule

/* dv/retransmit_timer_pool_tb.sv */
// Testbench for retransmit_timer_pool: random timer sessions checked against a built-in predictor.
`timescale 1ns / 100ps

module retransmit_timer_pool_tb;
  import rtp_pkg::*;

  // Scoreboard: tracks the pool state, predicts each reply, checks replies in order.
  class timer_pool_scoreboard;
    logic [CLOCK_W-1:0] now_ms;
    bit                 taken    [8];
    bit                 running  [8];
    bit                 expired  [8];
    logic [7:0]         retries  [8];
    logic [CLOCK_W-1:0] deadline [8];
    logic [15:0]        timeout_len;
    logic [7:0]         retry_limit;
    out_t               awaited_replies[$];
    int                 errors;

    function new();
      now_ms      = '0;
      timeout_len = TIMEOUT_RESET;
      retry_limit = RETRY_RESET;
      errors      = 0;
      for (int i = 0; i < 8; i++) begin
        taken[i]    = 1'b0;
        running[i]  = 1'b0;
        expired[i]  = 1'b0;
        retries[i]  = '0;
        deadline[i] = '0;
      end
    endfunction

    function void load_register(logic idx, logic [15:0] value);
      if (idx == CFG_TIMEOUT) timeout_len = value;
      else retry_limit = value[7:0];
    endfunction

    function int lowest_free();
      int s;
      s = -1;
      for (int i = 7; i >= 0; i--) if (!taken[i]) s = i;
      return s;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    // deadline one timeout ahead, pinned at the clock's top value
    function void arm_slot(int s);
      logic [CLOCK_W:0] sum;
      sum         = {1'b0, now_ms} + timeout_len;
      deadline[s] = sum[CLOCK_W] ? CLOCK_MAX : sum[CLOCK_W-1:0];
      expired[s]  = 1'b0;
      running[s]  = 1'b1;
    endfunction

    function out_t run_cmd(in_t c);
      out_t r;
      int   s;
      r = '0;
      s = c.slot;
      case (c.cmd)
        CMD_TICK: begin
          if (now_ms != CLOCK_MAX) now_ms = now_ms + 1'b1;
          return r;
        end
        CMD_ACQUIRE: begin
          s = lowest_free();
          if (s < 0) begin
            r.status = ST_NO_SLOT;
            return r;
          end
          taken[s]       = 1'b1;
          running[s]     = 1'b0;
          expired[s]     = 1'b0;
          retries[s]     = '0;
          r.granted_slot = 3'(s);
        end
        CMD_INIT: begin
          running[s]  = 1'b0;
          expired[s]  = 1'b0;
          retries[s]  = '0;
          deadline[s] = '0;
        end
        CMD_START: arm_slot(s);
        CMD_STOP: begin
          running[s] = 1'b0;
          expired[s] = 1'b0;
        end
        CMD_CHECK: begin
          if (!running[s] || now_ms < deadline[s]) begin
            r.status = ST_INVALID;
          end else begin
            expired[s] = 1'b1;
            running[s] = 1'b0;
          end
        end
        CMD_RETRY: begin
          if (retries[s] >= retry_limit) begin
            r.status = ST_EXHAUSTED;
          end else begin
            retries[s] = retries[s] + 1'b1;
            arm_slot(s);
          end
        end
        CMD_DEINIT: begin
          running[s] = 1'b0;
          expired[s] = 1'b0;
          retries[s] = '0;
        end
        CMD_RELEASE: taken[s] = 1'b0;
        default: r.status = ST_INVALID;
      endcase
      r.is_running   = running[s];
      r.is_expired   = expired[s];
      r.retry_left   = (retries[s] < retry_limit);
      r.retries_done = retries[s];
      return r;
    endfunction

    function void note_cmd(in_t c);
      awaited_replies.push_back(run_cmd(c));
    endfunction

    function void report(string what, int got, int want);
      errors++;
      $display("retransmit_timer_pool_tb: mismatch at %0t: %s got %0d want %0d",
               $realtime, what, got, want);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_replies.size() == 0) begin
        report("reply with nothing pending, status", got.status, 0);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status != want.status) report("status", got.status, want.status);
      if (got.granted_slot != want.granted_slot)
        report("granted_slot", got.granted_slot, want.granted_slot);
      if (got.is_running != want.is_running)
        report("is_running", got.is_running, want.is_running);
      if (got.is_expired != want.is_expired)
        report("is_expired", got.is_expired, want.is_expired);
      if (got.retry_left != want.retry_left)
        report("retry_left", got.retry_left, want.retry_left);
      if (got.retries_done != want.retries_done)
        report("retries_done", got.retries_done, want.retries_done);
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;  // cycles without any beat before giving up

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;

  timer_pool_scoreboard sb = new();

  int cmds_sent   = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  // receiver stall pattern state
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_hold      = 0;

  retransmit_timer_pool dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Result side: every accepted reply beat goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: switches between always ready, random ready, and long
  // on/off stretches so stalls land on every phase of a command.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 2);
      rx_mode_left <= $urandom_range(64, 256);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (rx_hold == 0) begin
          out_ready <= !out_ready;
          rx_hold   <= out_ready ? $urandom_range(1, 20) : $urandom_range(1, 10);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // Watchdog: a run with no beat on either side for too long is hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("retransmit_timer_pool_tb: done, errors");
      $finish;
    end
  end

  // Drive one command beat and wait for it to be taken. The sender works in
  // bursts; between bursts valid drops for a random gap (sometimes none).
  // The prediction is made here, at the accepting edge, so the generator
  // always sees the pool state including this command.
  task automatic send_cmd(logic [3:0] cmd, logic [2:0] slot);
    int gap;
    in_t beat;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.cmd  = cmd;
    beat.slot = slot;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_cmd(beat);
    cmds_sent++;
  endtask

  // Stop sending until every pending reply has come back; at least one
  // edge passes so valid is never driven twice in one step.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Both registers are written back to back after a short hold-off, once
  // every pending reply has come back and the pool is idle.
  task automatic set_timer_config(logic [15:0] timeout, logic [7:0] limit);
    hold_until_drained();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= timeout;
    @(posedge clk);
    sb.load_register(CFG_TIMEOUT, timeout);
    cfg_index <= CFG_RETRY;
    cfg_data  <= {8'h00, limit};
    @(posedge clk);
    sb.load_register(CFG_RETRY, {8'h00, limit});
    cfg_we <= 1'b0;
  endtask

  // Mostly a slot that is held, otherwise any slot.
  function automatic logic [2:0] pick_slot();
    int held[$];
    for (int i = 0; i < 8; i++) if (sb.taken[i]) held.push_back(i);
    if (held.size() != 0 && $urandom_range(0, 3) != 0)
      return 3'(held[$urandom_range(0, held.size() - 1)]);
    return 3'($urandom_range(0, 7));
  endfunction

  // One well-formed timer lifetime: acquire, sometimes init, start, wait
  // around the deadline, check, maybe retry for a few rounds, then stop,
  // deinit or neither, and usually release; held slots let the pool fill.
  task automatic run_session();
    int s;
    int span;
    s = sb.lowest_free();
    send_cmd(CMD_ACQUIRE, 3'($urandom_range(0, 7)));
    if (s < 0) return;
    if ($urandom_range(0, 3) == 0) send_cmd(CMD_INIT, 3'(s));
    send_cmd(CMD_START, 3'(s));
    repeat ($urandom_range(1, 4)) begin
      span = (sb.timeout_len > 12) ? 14 : sb.timeout_len + 2;
      repeat ($urandom_range(0, span)) send_cmd(CMD_TICK, 3'($urandom_range(0, 7)));
      send_cmd(CMD_CHECK, 3'(s));
      if ($urandom_range(0, 2) != 0) send_cmd(CMD_RETRY, 3'(s));
    end
    case ($urandom_range(0, 2))
      0: send_cmd(CMD_STOP, 3'(s));
      1: send_cmd(CMD_DEINIT, 3'(s));
      default: ;
    endcase
    if ($urandom_range(0, 9) < 7) send_cmd(CMD_RELEASE, 3'(s));
  endtask

  // Random part of a phase: mostly sessions, the rest loose commands of
  // any code (unknown ones included), with an occasional full drain.
  task automatic run_phase(int goal);
    int stop_at;
    stop_at = cmds_sent + goal;
    while (cmds_sent < stop_at) begin
      if ($urandom_range(0, 99) == 0) hold_until_drained();
      if ($urandom_range(0, 9) < 6) begin
        run_session();
      end else begin
        repeat ($urandom_range(1, 6))
          send_cmd(4'($urandom_range(0, 15)), pick_slot());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings (timeout 1000, limit 5).
    send_cmd(CMD_TICK, 3'd7);
    send_cmd(CMD_CHECK, 3'd0);          // free slot, not running
    repeat (8) send_cmd(CMD_ACQUIRE, 3'd5);
    send_cmd(CMD_ACQUIRE, 3'd0);        // pool full
    send_cmd(CMD_START, 3'd7);
    send_cmd(CMD_CHECK, 3'd7);          // deadline still ahead
    send_cmd(CMD_STOP, 3'd7);
    send_cmd(CMD_RETRY, 3'd0);
    send_cmd(CMD_DEINIT, 3'd0);
    send_cmd(CMD_INIT, 3'd3);
    send_cmd(CMD_RELEASE, 3'd7);
    send_cmd(CMD_RELEASE, 3'd0);
    send_cmd(CMD_ACQUIRE, 3'd2);        // lowest free is 0 again
    send_cmd(4'd9, 3'd5);               // unknown codes
    send_cmd(4'd15, 3'd2);
    send_cmd(CMD_START, 3'd7);          // acts on a slot that is not held

    // Lowest settings: every retry refused, deadline one tick out.
    set_timer_config(16'd1, 8'd0);
    run_phase(150);

    // Highest settings: walk one slot's retry count to the top and past it.
    set_timer_config(16'hFFFF, 8'hFF);
    send_cmd(CMD_DEINIT, 3'd6);
    repeat (260) send_cmd(CMD_RETRY, 3'd6);
    run_phase(60);

    // Zero timeout: deadline is the current time, expiry is immediate.
    set_timer_config(16'd0, 8'd3);
    run_phase(120);

    repeat (4) begin
      set_timer_config(16'($urandom_range(1, 12)), 8'($urandom_range(0, 8)));
      run_phase(120);
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("retransmit_timer_pool_tb: done, clean");
    else $display("retransmit_timer_pool_tb: done, errors");
    $finish;
  end

endmodule
